// ----- src/socks5_handshake_parser_assert.svh -----
// assertion macros for the handshake parser modules, included by s5hs_emit
// expects i_clk and i_rst_n in the scope of the module that includes it
`ifndef SOCKS5_HANDSHAKE_PARSER_ASSERT_SVH
`define SOCKS5_HANDSHAKE_PARSER_ASSERT_SVH

// condition holds in the same cycle as the antecedent
`define S5HS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition holds in the cycle after the antecedent
`define S5HS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/s5hs_pkg.sv -----
// types, codes and constants for the socks5 handshake parser
// no dependencies
package s5hs_pkg;

    // input and result payloads
    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       connect_ok;
    } t_in;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  out_byte;
        logic        last;
        logic [31:0] dest_address;
        logic [15:0] dest_port;
    } t_out;

    // burst of results produced by one input item
    localparam logic [1:0] BURST_SINGLE = 2'd0;
    localparam logic [1:0] BURST_GREET  = 2'd1;
    localparam logic [1:0] BURST_REPLY  = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [2:0]  kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] addr;
        logic [15:0] port;
        logic        tail_close;
    } t_burst;

    // result kinds
    localparam logic [2:0] KIND_REPLY      = 3'd0;
    localparam logic [2:0] KIND_NAME_CHAR  = 3'd1;
    localparam logic [2:0] KIND_IPV4_CONN  = 3'd2;
    localparam logic [2:0] KIND_NAME_CONN  = 3'd3;
    localparam logic [2:0] KIND_CLOSE      = 3'd4;
    localparam logic [2:0] KIND_RELAY      = 3'd5;

    // configuration register indexes
    localparam logic CFG_BIND_ADDRESS = 1'b0;
    localparam logic CFG_BIND_PORT    = 1'b1;

    // protocol bytes
    localparam logic [7:0] SOCKS_VER     = 8'h05;
    localparam logic [7:0] METHOD_NONE   = 8'h00;
    localparam logic [7:0] METHOD_REJECT = 8'hFF;
    localparam logic [7:0] CMD_CONNECT   = 8'h01;
    localparam logic [7:0] ADDR_IPV4     = 8'h01;
    localparam logic [7:0] ADDR_NAME     = 8'h03;
    localparam logic [7:0] RSV_BYTE      = 8'h00;
    localparam logic [7:0] CODE_OK       = 8'h00;
    localparam logic [7:0] CODE_VERSION  = 8'h01;
    localparam logic [7:0] CODE_CMD      = 8'h07;
    localparam logic [7:0] CODE_ATYP     = 8'h08;
    localparam logic [7:0] CHAR_UPPER_A  = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CASE_OFFSET   = 8'h20;

    // reply length in bytes
    localparam int REPLY_LEN = 10;

endpackage

// ----- src/s5hs_parse.sv -----
// handshake state and per-item decode into a result burst
// depends on s5hs_pkg
module s5hs_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  s5hs_pkg::t_in    i_in,
    output logic             o_emit,
    output s5hs_pkg::t_burst o_desc
);

    localparam logic [2:0] PH_GREET  = 3'd0;
    localparam logic [2:0] PH_REQ    = 3'd1;
    localparam logic [2:0] PH_WAIT   = 3'd2;
    localparam logic [2:0] PH_RELAY  = 3'd3;
    localparam logic [2:0] PH_CLOSED = 3'd4;

    logic [2:0]  r_phase, n_phase;
    logic [8:0]  r_cnt, n_cnt;
    logic [7:0]  r_mcount, n_mcount;
    logic        r_noauth, n_noauth;
    logic        r_vbad, n_vbad;
    logic [7:0]  r_code, n_code;
    logic [7:0]  r_atype, n_atype;
    logic [7:0]  r_nlen, n_nlen;
    logic [31:0] r_addr, n_addr;
    logic [15:0] r_port, n_port;

    logic [7:0]  w_b;
    logic [8:0]  w_cnt_inc;
    logic [8:0]  w_greet_end;
    logic [8:0]  w_name_end;
    logic [7:0]  w_lower;
    logic        w_fin_greet;
    logic        w_fin_req;
    logic        w_reject;

    assign w_b         = i_in.data_byte;
    assign w_cnt_inc   = r_cnt + 9'd1;
    assign w_greet_end = {1'b0, r_mcount} + 9'd2;
    assign w_name_end  = {1'b0, r_nlen} + 9'd5;
    assign w_lower     = (w_b >= s5hs_pkg::CHAR_UPPER_A && w_b <= s5hs_pkg::CHAR_UPPER_Z)
                         ? w_b + s5hs_pkg::CASE_OFFSET : w_b;

    always_comb begin
        n_phase     = r_phase;
        n_cnt       = r_cnt;
        n_mcount    = r_mcount;
        n_noauth    = r_noauth;
        n_vbad      = r_vbad;
        n_code      = r_code;
        n_atype     = r_atype;
        n_nlen      = r_nlen;
        n_addr      = r_addr;
        n_port      = r_port;
        w_fin_greet = 1'b0;
        w_fin_req   = 1'b0;
        w_reject    = 1'b0;
        o_emit      = 1'b0;
        o_desc      = '0;
        o_desc.mode = s5hs_pkg::BURST_SINGLE;

        if (i_in.cmd) begin
            if (r_phase == PH_WAIT) begin
                o_emit = 1'b1;
                if (i_in.connect_ok) begin
                    n_phase     = PH_RELAY;
                    o_desc.mode = s5hs_pkg::BURST_REPLY;
                    o_desc.data = r_code;
                end else begin
                    n_phase     = PH_CLOSED;
                    o_desc.kind = s5hs_pkg::KIND_CLOSE;
                end
            end
        end else begin
            case (r_phase)
                PH_GREET: begin
                    if (r_cnt == 9'd0) begin
                        n_vbad = (w_b != s5hs_pkg::SOCKS_VER);
                        n_cnt  = 9'd1;
                    end else if (r_cnt == 9'd1) begin
                        n_mcount    = w_b;
                        n_cnt       = 9'd2;
                        w_fin_greet = (w_b == 8'd0);
                    end else begin
                        if (w_b == s5hs_pkg::METHOD_NONE) begin
                            n_noauth = 1'b1;
                        end
                        n_cnt       = w_cnt_inc;
                        w_fin_greet = (w_cnt_inc == w_greet_end);
                    end
                end
                PH_REQ: begin
                    n_cnt = w_cnt_inc;
                    if (r_cnt == 9'd0) begin
                        n_code = (w_b != s5hs_pkg::SOCKS_VER) ? s5hs_pkg::CODE_VERSION
                                                              : s5hs_pkg::CODE_OK;
                    end else if (r_cnt == 9'd1) begin
                        if (w_b != s5hs_pkg::CMD_CONNECT) begin
                            n_code = s5hs_pkg::CODE_CMD;
                        end
                    end else if (r_cnt == 9'd3) begin
                        n_atype = w_b;
                        if (w_b != s5hs_pkg::ADDR_IPV4 && w_b != s5hs_pkg::ADDR_NAME) begin
                            o_emit            = 1'b1;
                            o_desc.mode       = s5hs_pkg::BURST_REPLY;
                            o_desc.data       = s5hs_pkg::CODE_ATYP;
                            o_desc.tail_close = 1'b1;
                            n_phase           = PH_CLOSED;
                        end
                    end else if (r_cnt >= 9'd4 && r_atype == s5hs_pkg::ADDR_IPV4) begin
                        if (r_cnt < 9'd8) begin
                            n_addr = {r_addr[23:0], w_b};
                        end else begin
                            n_port = {r_port[7:0], w_b};
                        end
                        w_fin_req = (r_cnt == 9'd9);
                    end else if (r_cnt >= 9'd4) begin
                        if (r_cnt == 9'd4) begin
                            n_nlen = w_b;
                        end else if (r_cnt < w_name_end) begin
                            // name characters are suppressed once the request is bad
                            if (r_code == s5hs_pkg::CODE_OK) begin
                                o_emit      = 1'b1;
                                o_desc.kind = s5hs_pkg::KIND_NAME_CHAR;
                                o_desc.data = w_lower;
                                o_desc.last = (w_cnt_inc == w_name_end);
                            end
                        end else begin
                            n_port    = {r_port[7:0], w_b};
                            w_fin_req = (r_cnt == w_name_end + 9'd1);
                        end
                    end
                end
                PH_RELAY: begin
                    o_emit      = 1'b1;
                    o_desc.kind = s5hs_pkg::KIND_RELAY;
                    o_desc.data = w_b;
                end
                default: begin
                end
            endcase
        end

        if (w_fin_greet) begin
            w_reject          = !(n_noauth && !r_vbad);
            o_emit            = 1'b1;
            o_desc.mode       = s5hs_pkg::BURST_GREET;
            o_desc.data       = w_reject ? s5hs_pkg::METHOD_REJECT : s5hs_pkg::METHOD_NONE;
            o_desc.tail_close = w_reject;
            if (w_reject) begin
                n_phase = PH_CLOSED;
            end else begin
                n_phase = PH_REQ;
                n_cnt   = 9'd0;
                n_code  = s5hs_pkg::CODE_OK;
            end
        end

        if (w_fin_req) begin
            o_emit = 1'b1;
            if (r_code != s5hs_pkg::CODE_OK) begin
                o_desc.mode       = s5hs_pkg::BURST_REPLY;
                o_desc.data       = r_code;
                o_desc.tail_close = 1'b1;
                n_phase           = PH_CLOSED;
            end else begin
                o_desc.kind = (r_atype == s5hs_pkg::ADDR_IPV4) ? s5hs_pkg::KIND_IPV4_CONN
                                                               : s5hs_pkg::KIND_NAME_CONN;
                o_desc.addr = (r_atype == s5hs_pkg::ADDR_IPV4) ? n_addr : 32'd0;
                o_desc.port = n_port;
                n_phase     = PH_WAIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_GREET;
            r_cnt    <= '0;
            r_mcount <= '0;
            r_noauth <= 1'b0;
            r_vbad   <= 1'b0;
            r_code   <= '0;
            r_atype  <= '0;
            r_nlen   <= '0;
            r_addr   <= '0;
            r_port   <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_mcount <= n_mcount;
            r_noauth <= n_noauth;
            r_vbad   <= n_vbad;
            r_code   <= n_code;
            r_atype  <= n_atype;
            r_nlen   <= n_nlen;
            r_addr   <= n_addr;
            r_port   <= n_port;
        end
    end

endmodule

// ----- src/s5hs_emit.sv -----
// result register and burst sequencer: walks one burst out, one result per cycle while the receiver is ready
// depends on s5hs_pkg and socks5_handshake_parser_assert.svh
`include "socks5_handshake_parser_assert.svh"

module s5hs_emit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  s5hs_pkg::t_burst i_desc,
    input  logic [31:0]      i_bind_address,
    input  logic [15:0]      i_bind_port,
    input  logic             i_out_ready,
    output logic             o_take,
    output logic             o_out_valid,
    output s5hs_pkg::t_out   o_out
);

    localparam logic [3:0] IDX_REPLY_LAST = 4'(s5hs_pkg::REPLY_LEN - 1);
    localparam logic [3:0] IDX_REPLY_MAX  = 4'(s5hs_pkg::REPLY_LEN);

    s5hs_pkg::t_burst r_desc;
    logic             r_valid;
    logic [3:0]       r_idx;
    logic             w_last;
    logic [7:0]       w_reply_byte;
    logic             w_stalled;
    logic             w_burst_head;
    logic             w_head_ok;

    always_comb begin
        case (r_desc.mode)
            s5hs_pkg::BURST_GREET: w_last = (r_idx == (r_desc.tail_close ? 4'd2 : 4'd1));
            s5hs_pkg::BURST_REPLY: w_last = (r_idx == (r_desc.tail_close ? IDX_REPLY_MAX
                                                                          : IDX_REPLY_LAST));
            default:               w_last = 1'b1;
        endcase
    end

    always_comb begin
        case (r_idx)
            4'd0:    w_reply_byte = s5hs_pkg::SOCKS_VER;
            4'd1:    w_reply_byte = r_desc.data;
            4'd2:    w_reply_byte = s5hs_pkg::RSV_BYTE;
            4'd3:    w_reply_byte = s5hs_pkg::ADDR_IPV4;
            4'd4:    w_reply_byte = i_bind_address[31:24];
            4'd5:    w_reply_byte = i_bind_address[23:16];
            4'd6:    w_reply_byte = i_bind_address[15:8];
            4'd7:    w_reply_byte = i_bind_address[7:0];
            4'd8:    w_reply_byte = i_bind_port[15:8];
            4'd9:    w_reply_byte = i_bind_port[7:0];
            default: w_reply_byte = 8'd0;
        endcase
    end

    always_comb begin
        o_out = '0;
        case (r_desc.mode)
            s5hs_pkg::BURST_SINGLE: begin
                o_out.kind         = r_desc.kind;
                o_out.out_byte     = r_desc.data;
                o_out.last         = r_desc.last;
                o_out.dest_address = r_desc.addr;
                o_out.dest_port    = r_desc.port;
            end
            s5hs_pkg::BURST_GREET: begin
                if (r_idx == 4'd0) begin
                    o_out.kind     = s5hs_pkg::KIND_REPLY;
                    o_out.out_byte = s5hs_pkg::SOCKS_VER;
                end else if (r_idx == 4'd1) begin
                    o_out.kind     = s5hs_pkg::KIND_REPLY;
                    o_out.out_byte = r_desc.data;
                    o_out.last     = 1'b1;
                end else begin
                    o_out.kind = s5hs_pkg::KIND_CLOSE;
                end
            end
            s5hs_pkg::BURST_REPLY: begin
                if (r_idx < IDX_REPLY_MAX) begin
                    o_out.kind     = s5hs_pkg::KIND_REPLY;
                    o_out.out_byte = w_reply_byte;
                    o_out.last     = (r_idx == IDX_REPLY_LAST);
                end else begin
                    o_out.kind = s5hs_pkg::KIND_CLOSE;
                end
            end
            default: begin
            end
        endcase
    end

    // a new burst may load while the final result of the current one leaves
    assign o_take      = !r_valid || (i_out_ready && w_last);
    assign o_out_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (o_take) begin
            r_valid <= i_load;
            r_idx   <= '0;
        end else if (i_out_ready) begin
            r_idx <= r_idx + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_take) begin
            r_desc <= i_desc;
        end
    end

    assign w_stalled    = r_valid && !i_out_ready;
    assign w_burst_head = r_valid && r_idx == 4'd0 && r_desc.mode != s5hs_pkg::BURST_SINGLE;
    assign w_head_ok    = o_out.kind == s5hs_pkg::KIND_REPLY
                          && o_out.out_byte == s5hs_pkg::SOCKS_VER;

    `S5HS_ASSERT_SAME(a_idx_bound, r_valid, r_idx <= IDX_REPLY_MAX, "burst index out of range")
    `S5HS_ASSERT_NEXT(a_stall_hold, w_stalled, r_valid && $stable(r_idx), "burst moved in stall")
    `S5HS_ASSERT_SAME(a_burst_head, w_burst_head, w_head_ok, "burst not opened by version")

endmodule

// ----- src/socks5_handshake_parser.sv -----
// Server-side socks5 handshake for one connection.
// Input channel (i_in_valid / o_in_ready / i_in): one client byte (cmd 0) or one
// remote connect result (cmd 1) per request. Output channel (o_out_valid /
// i_out_ready / o_out): result items: reply bytes, lowercased name characters,
// connect requests, close, relayed bytes.
// Each accepted item is decoded in the cycle it is accepted and its results appear
// from the next cycle, one per cycle while the receiver is ready.
// An item with one result or none leaves the input ready, so relay and name bytes
// run at one per cycle while the receiver is ready. An item that causes a reply
// occupies the burst sequencer for two or three results (greeting answer) or ten or
// eleven results (request reply, with close on error); input is held off until its
// last result is taken. When the receiver stalls, the current result holds and input
// stops once the sequencer is busy. Configuration writes (bind address, bind port)
// take effect at once; the user must make them only while idle, unchecked by the block.
// Synchronous active-low reset returns to the greeting phase, clears the bind
// registers and drops any pending results.
// depends on s5hs_pkg, s5hs_parse, s5hs_emit
module socks5_handshake_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  s5hs_pkg::t_in  i_in,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output s5hs_pkg::t_out o_out,
    input  logic           i_cfg_we,
    input  logic           i_cfg_idx,
    input  logic [31:0]    i_cfg_data
);

    logic [31:0]      r_bind_address;
    logic [15:0]      r_bind_port;
    logic             w_take;
    logic             w_accept;
    logic             w_emit;
    s5hs_pkg::t_burst w_desc;

    assign o_in_ready = w_take;
    assign w_accept   = i_in_valid && w_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bind_address <= '0;
            r_bind_port    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                s5hs_pkg::CFG_BIND_ADDRESS: r_bind_address <= i_cfg_data;
                s5hs_pkg::CFG_BIND_PORT:    r_bind_port    <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    s5hs_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_in     (i_in),
        .o_emit   (w_emit),
        .o_desc   (w_desc)
    );

    s5hs_emit u_emit (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_accept && w_emit),
        .i_desc         (w_desc),
        .i_bind_address (r_bind_address),
        .i_bind_port    (r_bind_port),
        .i_out_ready    (i_out_ready),
        .o_take         (w_take),
        .o_out_valid    (o_out_valid),
        .o_out          (o_out)
    );

endmodule

// ----- dv/tb_socks5_handshake_parser.sv -----
`timescale 1ns / 100ps
// self-checking testbench for socks5_handshake_parser: directed handshake, then random relay
// traffic under several idle and stall patterns, results checked against a local predictor
// depends on s5hs_pkg and socks5_handshake_parser
module tb_socks5_handshake_parser;
    import s5hs_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int HOLD_CYCLES     = 300;
    localparam int SETTLE_CYCLES   = 24;
    localparam int ITEMS_PER_PHASE = 74;
    localparam int IPV4_REQ_LEN    = 10;
    localparam int NAME_REQ_EXTRA  = 7;
    localparam int SEND_IDLE[4]    = '{0, 88, 0, 15};
    localparam int RECV_STALL[4]   = '{0, 0, 88, 15};

    typedef enum logic [2:0] {
        PH_GREETING, PH_REQUEST, PH_WAITING, PH_RELAY, PH_CLOSED
    } t_phase;

    typedef struct {
        t_in  item;
        logic pause;
        logic chk;
        t_out want;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    t_in         i_in;
    logic        o_out_valid;
    logic        i_out_ready;
    t_out        o_out;
    logic        i_cfg_we;
    logic        i_cfg_idx;
    logic [31:0] i_cfg_data;

    // typed-in expectation travelling with the request on the input channel
    logic drv_chk;
    t_out drv_want;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_ask;
    int fail_count;
    int results_checked;
    int requests_sent;
    int cycle_count;

    t_out pending_results[$];

    // predictor state
    logic [31:0] cfg_bind_addr = '0;
    logic [15:0] cfg_bind_port = '0;
    t_phase      cur_phase     = PH_GREETING;
    logic [8:0]  rx_count      = '0;
    logic [7:0]  method_total  = '0;
    logic        saw_noauth    = 1'b0;
    logic        bad_version   = 1'b0;
    logic [7:0]  err_code      = CODE_OK;
    logic [7:0]  atyp          = '0;
    logic [7:0]  name_len      = '0;
    logic [31:0] dst_addr      = '0;
    logic [15:0] dst_port      = '0;

    socks5_handshake_parser i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_out mk_result(logic [2:0] kind, logic [7:0] b, logic last,
                                       logic [31:0] addr, logic [15:0] port);
        t_out r;
        r.kind         = kind;
        r.out_byte     = b;
        r.last         = last;
        r.dest_address = addr;
        r.dest_port    = port;
        return r;
    endfunction

    function void push_result(logic [2:0] kind, logic [7:0] b, logic last,
                              logic [31:0] addr, logic [15:0] port);
        pending_results.push_back(mk_result(kind, b, last, addr, port));
    endfunction

    // ten-byte reply carrying the bind address and port, high byte first
    function void push_bind_reply(logic [7:0] code);
        int i;
        push_result(KIND_REPLY, SOCKS_VER, 1'b0, '0, '0);
        push_result(KIND_REPLY, code, 1'b0, '0, '0);
        push_result(KIND_REPLY, RSV_BYTE, 1'b0, '0, '0);
        push_result(KIND_REPLY, ADDR_IPV4, 1'b0, '0, '0);
        for (i = 3; i >= 0; i--)
            push_result(KIND_REPLY, cfg_bind_addr[i*8 +: 8], 1'b0, '0, '0);
        push_result(KIND_REPLY, cfg_bind_port[15:8], 1'b0, '0, '0);
        push_result(KIND_REPLY, cfg_bind_port[7:0], 1'b1, '0, '0);
    endfunction

    function void push_close();
        push_result(KIND_CLOSE, 8'h00, 1'b0, '0, '0);
        cur_phase = PH_CLOSED;
    endfunction

    function void reject_request(logic [7:0] code);
        push_bind_reply(code);
        push_close();
    endfunction

    function void answer_greeting();
        logic [7:0] method;
        method = (saw_noauth && !bad_version) ? METHOD_NONE : METHOD_REJECT;
        push_result(KIND_REPLY, SOCKS_VER, 1'b0, '0, '0);
        push_result(KIND_REPLY, method, 1'b1, '0, '0);
        if (method == METHOD_REJECT) begin
            push_close();
        end else begin
            cur_phase = PH_REQUEST;
            rx_count  = '0;
            err_code  = CODE_OK;
        end
    endfunction

    function void conclude_request();
        if (err_code != CODE_OK) begin
            reject_request(err_code);
        end else begin
            if (atyp == ADDR_IPV4)
                push_result(KIND_IPV4_CONN, 8'h00, 1'b0, dst_addr, dst_port);
            else
                push_result(KIND_NAME_CONN, 8'h00, 1'b0, '0, dst_port);
            cur_phase = PH_WAITING;
        end
    endfunction

    function void request_byte(logic [7:0] b);
        int         c;
        int         nl;
        logic [7:0] ch;
        c        = rx_count;
        nl       = name_len;
        rx_count = rx_count + 9'd1;
        if (c == 0) begin
            err_code = (b != SOCKS_VER) ? CODE_VERSION : CODE_OK;
        end else if (c == 1) begin
            // a bad command outranks a bad version
            if (b != CMD_CONNECT)
                err_code = CODE_CMD;
        end else if (c == 3) begin
            atyp = b;
            if (b != ADDR_IPV4 && b != ADDR_NAME)
                reject_request(CODE_ATYP);
        end else if (c >= 4 && atyp == ADDR_IPV4) begin
            if (c < 8)
                dst_addr = {dst_addr[23:0], b};
            else
                dst_port = {dst_port[7:0], b};
            if (c + 1 == IPV4_REQ_LEN)
                conclude_request();
        end else if (c >= 4) begin
            if (c == 4) begin
                name_len = b;
            end else if (c < 5 + nl) begin
                // name characters are held back once the request is known to be bad
                if (err_code == CODE_OK) begin
                    ch = (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ? b + CASE_OFFSET : b;
                    push_result(KIND_NAME_CHAR, ch, c == 4 + nl, '0, '0);
                end
            end else begin
                dst_port = {dst_port[7:0], b};
                if (c + 1 == NAME_REQ_EXTRA + nl)
                    conclude_request();
            end
        end
    endfunction

    function void predict_handshake(t_in it);
        logic [7:0] b;
        b = it.data_byte;
        if (it.cmd) begin
            if (cur_phase == PH_WAITING) begin
                if (it.connect_ok) begin
                    cur_phase = PH_RELAY;
                    push_bind_reply(err_code);
                end else begin
                    push_close();
                end
            end
        end else begin
            case (cur_phase)
                PH_GREETING: begin
                    if (rx_count == 0) begin
                        bad_version = (b != SOCKS_VER);
                        rx_count    = 9'd1;
                    end else if (rx_count == 1) begin
                        method_total = b;
                        rx_count     = 9'd2;
                        if (b == 8'd0)
                            answer_greeting();
                    end else begin
                        if (b == METHOD_NONE)
                            saw_noauth = 1'b1;
                        rx_count = rx_count + 9'd1;
                        if (rx_count == 2 + method_total)
                            answer_greeting();
                    end
                end
                PH_REQUEST: request_byte(b);
                PH_RELAY:   push_result(KIND_RELAY, b, 1'b0, '0, '0);
                default:    ;
            endcase
        end
    endfunction

    function void check_result(string what, t_out want, t_out got);
        if (got.kind !== want.kind) begin
            $error("%s kind: expected %0d, got %0d", what, want.kind, got.kind);
            fail_count++;
        end
        if (got.out_byte !== want.out_byte) begin
            $error("%s out_byte: expected %02h, got %02h", what, want.out_byte, got.out_byte);
            fail_count++;
        end
        if (got.last !== want.last) begin
            $error("%s last: expected %0d, got %0d", what, want.last, got.last);
            fail_count++;
        end
        if (got.dest_address !== want.dest_address) begin
            $error("%s dest_address: expected %08h, got %08h", what, want.dest_address,
                   got.dest_address);
            fail_count++;
        end
        if (got.dest_port !== want.dest_port) begin
            $error("%s dest_port: expected %04h, got %04h", what, want.dest_port,
                   got.dest_port);
            fail_count++;
        end
    endfunction

    function automatic t_row mk_row(logic cmd, logic [7:0] b, logic ok, logic pause,
                                    logic chk, t_out want);
        t_row r;
        r.item.cmd        = cmd;
        r.item.data_byte  = b;
        r.item.connect_ok = ok;
        r.pause           = pause;
        r.chk             = chk;
        r.want            = want;
        return r;
    endfunction

    // monitor: config mirror, result checking, prediction on every accepted request
    always @(posedge i_clk) begin : monitor
        t_out exp_r;
        int   depth;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BIND_ADDRESS)
                    cfg_bind_addr = i_cfg_data;
                else
                    cfg_bind_port = i_cfg_data[15:0];
            end
            if (o_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    $error("unexpected result: kind %0d, out_byte %02h", o_out.kind,
                           o_out.out_byte);
                    fail_count++;
                end else begin
                    exp_r = pending_results.pop_front();
                    check_result("result", exp_r, o_out);
                    results_checked++;
                end
            end
            if (i_in_valid && o_in_ready) begin
                depth = pending_results.size();
                predict_handshake(i_in);
                if (drv_chk) begin
                    if (pending_results.size() == depth) begin
                        $error("directed row: expected a result, predicted none");
                        fail_count++;
                    end else begin
                        check_result("directed row", drv_want, pending_results[$]);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, plus a long hold-off whenever one is asked for
    initial begin : receiver
        int hold_left;
        int hold_seen;
        hold_left   = 0;
        hold_seen   = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_seen != hold_ask) begin
                hold_seen = hold_ask;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    task automatic push_request(input t_in it, input logic chk, input t_out want);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in       <= it;
        i_in_valid <= 1'b1;
        drv_chk    <= chk;
        drv_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
        requests_sent++;
    endtask

    // hold the input until every predicted result is out, then let the block settle
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_row rows[$];
        t_in  it;
        t_out no_want;
        int   ph;
        int   i;
        no_want         = '0;
        fail_count      = 0;
        results_checked = 0;
        requests_sent   = 0;
        cycle_count     = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in       <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_BIND_ADDRESS;
        i_cfg_data <= '0;
        drv_chk    <= 1'b0;
        drv_want   <= '0;
        hold_ask   <= 0;

        // connect events outside the waiting phase are dropped
        rows.push_back(mk_row(1'b1, 8'hA5, 1'b0, 1'b0, 1'b0, no_want));
        // greeting offering an unknown method, reject and no-auth
        rows.push_back(mk_row(1'b0, SOCKS_VER, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, 8'h03, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, METHOD_REJECT, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, 8'h01, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, METHOD_NONE, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_REPLY, METHOD_NONE, 1'b1, '0, '0)));
        rows.push_back(mk_row(1'b1, 8'h5A, 1'b1, 1'b0, 1'b0, no_want));
        // connect request to a domain name, case folding at the letter boundaries
        rows.push_back(mk_row(1'b0, SOCKS_VER, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, CMD_CONNECT, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, RSV_BYTE, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, ADDR_NAME, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, 8'd8, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, CHAR_UPPER_A, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_NAME_CHAR, 8'h61, 1'b0, '0, '0)));
        rows.push_back(mk_row(1'b0, CHAR_UPPER_Z, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_NAME_CHAR, 8'h7A, 1'b0, '0, '0)));
        rows.push_back(mk_row(1'b0, 8'h40, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_NAME_CHAR, 8'h40, 1'b0, '0, '0)));
        rows.push_back(mk_row(1'b0, 8'h5B, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_NAME_CHAR, 8'h5B, 1'b0, '0, '0)));
        rows.push_back(mk_row(1'b0, 8'h61, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, 8'h7A, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, 8'hFF, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_NAME_CHAR, 8'hFF, 1'b1, '0, '0)));
        rows.push_back(mk_row(1'b0, 8'hFF, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_NAME_CONN, 8'h00, 1'b0, '0, 16'hFF00)));
        // successful connect once the bind port has been moved to its top value
        rows.push_back(mk_row(1'b1, 8'h00, 1'b1, 1'b1, 1'b1,
                              mk_result(KIND_REPLY, 8'hFF, 1'b1, '0, '0)));
        rows.push_back(mk_row(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, no_want));
        rows.push_back(mk_row(1'b0, 8'h00, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_RELAY, 8'h00, 1'b0, '0, '0)));
        rows.push_back(mk_row(1'b0, 8'hFF, 1'b0, 1'b0, 1'b1,
                              mk_result(KIND_RELAY, 8'hFF, 1'b0, '0, '0)));

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        cfg_write(CFG_BIND_ADDRESS, 32'hFFFF_FFFF);
        cfg_write(CFG_BIND_PORT, 32'h0000_0000);

        foreach (rows[r]) begin
            if (rows[r].pause) begin
                wait_drain();
                cfg_write(CFG_BIND_PORT, 32'h0000_FFFF);
            end
            push_request(rows[r].item, rows[r].chk, rows[r].want);
        end

        for (ph = 0; ph < 4; ph++) begin
            wait_drain();
            case (ph)
                0: begin
                    cfg_write(CFG_BIND_ADDRESS, $urandom);
                    cfg_write(CFG_BIND_PORT, $urandom_range(65535));
                end
                1: begin
                    cfg_write(CFG_BIND_ADDRESS, 32'h0000_0000);
                    cfg_write(CFG_BIND_PORT, 32'h0000_0000);
                end
                2: begin
                    cfg_write(CFG_BIND_ADDRESS, 32'hFFFF_FFFF);
                    cfg_write(CFG_BIND_PORT, $urandom_range(65535));
                end
                default: begin
                    cfg_write(CFG_BIND_ADDRESS, $urandom);
                    cfg_write(CFG_BIND_PORT, 32'h0000_FFFF);
                end
            endcase
            send_idle_pct  = SEND_IDLE[ph];
            recv_stall_pct = RECV_STALL[ph];
            for (i = 0; i < ITEMS_PER_PHASE; i++) begin
                // long receiver hold-off while requests keep coming
                if (ph == 0 && i == 20)
                    hold_ask <= hold_ask + 1;
                if (ph == 2 && i == ITEMS_PER_PHASE / 2)
                    wait_drain();
                it.cmd        = ($urandom_range(99) < 10);
                it.data_byte  = $urandom_range(255);
                it.connect_ok = $urandom_range(1);
                push_request(it, 1'b0, no_want);
            end
        end

        wait_drain();
        $display("run covered the greeting, a domain-name connect, the bind reply and relay");
        $display("traffic: %0d requests sent, %0d results checked, %0d mismatches",
                 requests_sent, results_checked, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
